// File: sv/lkt_pkg.sv
package lkt_pkg;

    localparam int NUM_LOCKS   = 64;
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_WIDTH    = 16;

    localparam int IDX_W   = $clog2(NUM_LOCKS);
    localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int WADDR_W = IDX_W + SLOT_W;
    localparam int VER_W   = 64;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 3;
    localparam int LIDX_W  = 6;   // lock_index field width
    localparam int REQ_W   = 16;  // requester / owner_id field width

    localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [ST_W-1:0] ST_RECURSIVE   = 3'd2;
    localparam logic [ST_W-1:0] ST_PENDING     = 3'd3;
    localparam logic [ST_W-1:0] ST_HELD_OTHERS = 3'd4;
    localparam logic [ST_W-1:0] ST_QUEUE_FULL  = 3'd5;

    typedef struct packed {
        logic                held;
        logic [ID_WIDTH-1:0] owner;
        logic [VER_W-1:0]    version;
        logic [CNT_W-1:0]    count;
    } entry_t;

    // memory access group from control to storage
    typedef struct packed {
        logic                ent_rd_en;
        logic [IDX_W-1:0]    ent_rd_addr;
        logic                ent_wr_en;
        logic [IDX_W-1:0]    ent_wr_addr;
        entry_t              ent_wr_data;
        logic                set_valid;
        logic                wt_rd_en;
        logic [WADDR_W-1:0]  wt_rd_addr;
        logic                wt_wr_en;
        logic [WADDR_W-1:0]  wt_wr_addr;
        logic [ID_WIDTH-1:0] wt_wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                kind;
        logic [ST_W-1:0]     status;
        logic [ID_WIDTH-1:0] owner;
        logic                holder_valid;
        logic [VER_W-1:0]    version;
        logic                last;
    } res_t;

endpackage

// File: sv/lkt_if.sv
interface lkt_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [lkt_pkg::CMD_W-1:0]       cmd;
    logic [lkt_pkg::LIDX_W-1:0]      lock_index;
    logic [lkt_pkg::REQ_W-1:0]       requester;
    logic                            create_if_missing;

    modport source (output valid, cmd, lock_index, requester, create_if_missing,
                    input ready);
    modport sink (input valid, cmd, lock_index, requester, create_if_missing,
                  output ready);
endinterface

interface lkt_res_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [lkt_pkg::ST_W-1:0]        status;
    logic [lkt_pkg::REQ_W-1:0]       owner_id;
    logic                            holder_valid;
    logic [lkt_pkg::VER_W-1:0]       lock_version;
    logic                            last;

    modport source (output valid, kind, status, owner_id, holder_valid,
                    lock_version, last, input ready);
    modport sink (input valid, kind, status, owner_id, holder_valid,
                  lock_version, last, output ready);
endinterface

// File: sv/lkt_store.sv
module lkt_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkt_pkg::mem_req_t             req,
    output lkt_pkg::entry_t               ent_rd_data,
    output logic                          ent_valid,
    output logic [lkt_pkg::ID_WIDTH-1:0]  wt_rd_data
);

    lkt_pkg::entry_t               ent_mem [lkt_pkg::NUM_LOCKS];
    logic [lkt_pkg::ID_WIDTH-1:0]  wt_mem [lkt_pkg::NUM_LOCKS * lkt_pkg::QUEUE_DEPTH];
    logic [lkt_pkg::NUM_LOCKS-1:0] valid_reg;
    logic                          valid_rd_reg;
    lkt_pkg::entry_t               ent_rd_reg;
    logic [lkt_pkg::ID_WIDTH-1:0]  wt_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (req.set_valid)
            begin
                valid_reg[req.ent_wr_addr] <= 1'b1;
            end
            if (req.ent_rd_en)
            begin
                valid_rd_reg <= valid_reg[req.ent_rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ent_wr_en)
        begin
            ent_mem[req.ent_wr_addr] <= req.ent_wr_data;
        end
        if (req.ent_rd_en)
        begin
            ent_rd_reg <= ent_mem[req.ent_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wt_wr_en)
        begin
            wt_mem[req.wt_wr_addr] <= req.wt_wr_data;
        end
        if (req.wt_rd_en)
        begin
            wt_rd_reg <= wt_mem[req.wt_rd_addr];
        end
    end

    assign ent_rd_data = ent_rd_reg;
    assign ent_valid   = valid_rd_reg;
    assign wt_rd_data  = wt_rd_reg;

endmodule

// File: sv/fifo_lock_table.sv
// Channel  | Dir | Beat contents
// request  | in  | cmd, lock_index, requester, create_if_missing
// result   | out | kind, status, owner_id, holder_valid, lock_version, last
//
// One command at a time. Lock, query and most unlocks go from accept through S_ENT
// and S_EMIT to the result register, then back to S_IDLE before the next accept;
// unlock-with-handoff and cancel on a non-empty queue read (S_SRD) and shift (S_SWT)
// each queued waiter in the waiter memory, then S_FIN writes the entry. A new command
// is taken while the last result beat still waits. Reset clears the valid bits
// only; no clearing pass. A stalled result holds the sequencer in its emit state.
module fifo_lock_table (
    input  logic        clk,
    input  logic        rst_n,
    lkt_cmd_if.sink     request,
    lkt_res_if.source   result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENT  = 3'd1; // entry read data back, decide
    localparam logic [2:0] S_SRD  = 3'd2; // issue waiter read
    localparam logic [2:0] S_SWT  = 3'd3; // waiter data back, shift
    localparam logic [2:0] S_FIN  = 3'd4; // queue walk done, write entry (cancel: only on a match)
    localparam logic [2:0] S_EMIT = 3'd5; // hand results to output register

    logic [2:0]                        state_reg, state_next;
    logic [lkt_pkg::CMD_W-1:0]         cmd_reg;
    logic [lkt_pkg::IDX_W-1:0]         idx_reg;
    logic [lkt_pkg::ID_WIDTH-1:0]      req_reg;
    logic                              create_reg;
    lkt_pkg::entry_t                   ent_reg, ent_next;
    logic [lkt_pkg::CNT_W-1:0]         k_reg, k_next;
    logic                              shift_reg, shift_next;
    logic [lkt_pkg::ID_WIDTH-1:0]      nxt_owner_reg, nxt_owner_next;
    lkt_pkg::res_t                     res0_reg, res0_next;
    lkt_pkg::res_t                     res1_reg, res1_next;
    logic                              two_reg, two_next;
    logic                              sel_reg, sel_next;
    lkt_pkg::res_t                     out_reg, out_next;
    logic                              out_valid_reg, out_valid_next;

    lkt_pkg::mem_req_t                 mreq;
    lkt_pkg::entry_t                   ent_rd;
    logic                              ent_v;
    logic [lkt_pkg::ID_WIDTH-1:0]      wt_rd;

    logic                              in_acc;
    logic                              slot_free;
    logic                              match;
    logic [lkt_pkg::VER_W-1:0]         ver_inc;

    lkt_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (mreq),
        .ent_rd_data (ent_rd),
        .ent_valid   (ent_v),
        .wt_rd_data  (wt_rd)
    );

    function automatic lkt_pkg::res_t mk_res(
        input logic                         kind,
        input logic [lkt_pkg::ST_W-1:0]     status,
        input logic [lkt_pkg::ID_WIDTH-1:0] owner,
        input logic                         hv,
        input logic [lkt_pkg::VER_W-1:0]    ver,
        input logic                         last
    );
        lkt_pkg::res_t r;
        r.kind         = kind;
        r.status       = status;
        r.owner        = owner;
        r.holder_valid = hv;
        r.version      = ver;
        r.last         = last;
        return r;
    endfunction

    assign request.ready = (state_reg == S_IDLE);
    assign in_acc        = request.valid && request.ready;
    assign slot_free     = !out_valid_reg || result.ready;
    assign ver_inc       = ent_reg.version + 64'd1;
    // pop takes slot 0; cancel takes the first waiter equal to the requester
    assign match         = (cmd_reg == lkt_pkg::CMD_UNLOCK) ? (k_reg == '0)
                                                            : (wt_rd == req_reg);

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        k_next         = k_reg;
        shift_next     = shift_reg;
        nxt_owner_next = nxt_owner_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        two_next       = two_reg;
        sel_next       = sel_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        mreq             = '0;
        mreq.ent_rd_addr = request.lock_index[lkt_pkg::IDX_W-1:0];
        mreq.ent_wr_addr = idx_reg;
        mreq.wt_rd_addr  = {idx_reg, k_reg[lkt_pkg::SLOT_W-1:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mreq.ent_rd_en = 1'b1;
                    state_next     = S_ENT;
                end
            end
            S_ENT:
            begin
                ent_next   = ent_rd;
                k_next     = '0;
                shift_next = 1'b0;
                two_next   = 1'b0;
                sel_next   = 1'b0;
                state_next = S_EMIT;
                res0_next  = mk_res(1'b0, lkt_pkg::ST_NOT_FOUND, '0, 1'b0, '0, 1'b1);
                unique case (cmd_reg)
                    lkt_pkg::CMD_LOCK:
                    begin
                        if (!ent_v)
                        begin
                            if (create_reg)
                            begin
                                mreq.ent_wr_en   = 1'b1;
                                mreq.set_valid   = 1'b1;
                                mreq.ent_wr_data = '{held: 1'b1, owner: req_reg,
                                                     version: 64'd1, count: '0};
                                res0_next = mk_res(1'b0, lkt_pkg::ST_OK, req_reg, 1'b1,
                                                   64'd1, 1'b1);
                            end
                        end
                        else if (ent_rd.held)
                        begin
                            if (ent_rd.owner == req_reg)
                            begin
                                res0_next = mk_res(1'b0, lkt_pkg::ST_RECURSIVE, req_reg,
                                                   1'b1, ent_rd.version, 1'b1);
                            end
                            else if (ent_rd.count >= lkt_pkg::CNT_W'(lkt_pkg::QUEUE_DEPTH))
                            begin
                                res0_next = mk_res(1'b0, lkt_pkg::ST_QUEUE_FULL, '0, 1'b0,
                                                   '0, 1'b1);
                            end
                            else
                            begin
                                mreq.wt_wr_en    = 1'b1;
                                mreq.wt_wr_addr  = {idx_reg,
                                                    ent_rd.count[lkt_pkg::SLOT_W-1:0]};
                                mreq.wt_wr_data  = req_reg;
                                mreq.ent_wr_en   = 1'b1;
                                mreq.ent_wr_data = ent_rd;
                                mreq.ent_wr_data.count = ent_rd.count + 1'b1;
                                res0_next = mk_res(1'b0, lkt_pkg::ST_PENDING, '0, 1'b0,
                                                   '0, 1'b1);
                            end
                        end
                        else
                        begin
                            mreq.ent_wr_en   = 1'b1;
                            mreq.ent_wr_data = '{held: 1'b1, owner: req_reg,
                                                 version: ent_rd.version + 64'd1,
                                                 count: ent_rd.count};
                            res0_next = mk_res(1'b0, lkt_pkg::ST_OK, req_reg, 1'b1,
                                               ent_rd.version + 64'd1, 1'b1);
                        end
                    end
                    lkt_pkg::CMD_UNLOCK:
                    begin
                        if (ent_v)
                        begin
                            if (!ent_rd.held || ent_rd.owner != req_reg)
                            begin
                                res0_next = mk_res(1'b0, lkt_pkg::ST_HELD_OTHERS, '0,
                                                   1'b0, '0, 1'b1);
                            end
                            else if (ent_rd.count != '0)
                            begin
                                state_next = S_SRD;
                            end
                            else
                            begin
                                mreq.ent_wr_en   = 1'b1;
                                mreq.ent_wr_data = '{held: 1'b0, owner: '0,
                                                     version: ent_rd.version + 64'd1,
                                                     count: '0};
                                res0_next = mk_res(1'b0, lkt_pkg::ST_OK, '0, 1'b0, '0,
                                                   1'b1);
                            end
                        end
                    end
                    lkt_pkg::CMD_CANCEL:
                    begin
                        if (ent_v)
                        begin
                            if (ent_rd.count != '0)
                            begin
                                state_next = S_SRD;
                            end
                            else
                            begin
                                res0_next = mk_res(1'b0, lkt_pkg::ST_NOT_FOUND,
                                                   ent_rd.held ? ent_rd.owner : '0,
                                                   ent_rd.held, ent_rd.version, 1'b1);
                            end
                        end
                    end
                    lkt_pkg::CMD_QUERY:
                    begin
                        if (ent_v)
                        begin
                            res0_next = mk_res(1'b0, lkt_pkg::ST_OK,
                                               ent_rd.held ? ent_rd.owner : '0,
                                               ent_rd.held, ent_rd.version, 1'b1);
                        end
                    end
                endcase
            end
            S_SRD:
            begin
                mreq.wt_rd_en = 1'b1;
                state_next    = S_SWT;
            end
            S_SWT:
            begin
                if (shift_reg)
                begin
                    mreq.wt_wr_en   = 1'b1;
                    mreq.wt_wr_addr = {idx_reg,
                                       lkt_pkg::SLOT_W'(k_reg - lkt_pkg::CNT_W'(1))};
                    mreq.wt_wr_data = wt_rd;
                end
                else if (match)
                begin
                    shift_next     = 1'b1;
                    nxt_owner_next = wt_rd;
                end
                k_next     = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 == ent_reg.count) ? S_FIN : S_SRD;
            end
            S_FIN:
            begin
                state_next = S_EMIT;
                if (cmd_reg == lkt_pkg::CMD_UNLOCK)
                begin
                    mreq.ent_wr_en   = 1'b1;
                    mreq.ent_wr_data = '{held: 1'b1, owner: nxt_owner_reg,
                                         version: ver_inc,
                                         count: ent_reg.count - 1'b1};
                    res0_next = mk_res(1'b0, lkt_pkg::ST_OK, '0, 1'b0, '0, 1'b0);
                    res1_next = mk_res(1'b1, lkt_pkg::ST_OK, nxt_owner_reg, 1'b1,
                                       ver_inc, 1'b1);
                    two_next  = 1'b1;
                end
                else
                begin
                    // cancel: a match was found iff the shift started
                    mreq.ent_wr_en   = shift_reg;
                    mreq.ent_wr_data = ent_reg;
                    mreq.ent_wr_data.count = ent_reg.count - 1'b1;
                    res0_next = mk_res(1'b0,
                                       shift_reg ? lkt_pkg::ST_OK : lkt_pkg::ST_NOT_FOUND,
                                       ent_reg.held ? ent_reg.owner : '0,
                                       ent_reg.held, ent_reg.version, 1'b1);
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = sel_reg ? res1_reg : res0_reg;
                    out_valid_next = 1'b1;
                    if (two_reg && !sel_reg)
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        sel_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
            two_reg       <= 1'b0;
            shift_reg     <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
            two_reg       <= two_next;
            shift_reg     <= shift_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg    <= request.cmd;
            idx_reg    <= request.lock_index[lkt_pkg::IDX_W-1:0];
            req_reg    <= request.requester[lkt_pkg::ID_WIDTH-1:0];
            create_reg <= request.create_if_missing;
        end
        ent_reg       <= ent_next;
        nxt_owner_reg <= nxt_owner_next;
        res0_reg      <= res0_next;
        res1_reg      <= res1_next;
        out_reg       <= out_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_reg.kind;
    assign result.status       = out_reg.status;
    assign result.owner_id     = lkt_pkg::REQ_W'(out_reg.owner);
    assign result.holder_valid = out_reg.holder_valid;
    assign result.lock_version = out_reg.version;
    assign result.last         = out_reg.last;

    // a grant notice always names a holder and closes the command
    a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind |-> result.last && result.holder_valid)
        else $error("grant notice not last or without holder");

    // only the handoff reply is non-final, and it is ok
    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.last |-> result.status == lkt_pkg::ST_OK && !result.kind)
        else $error("unexpected non-final beat");

    // the grant follows its reply in the very next cycle
    a_grant_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !result.last |=> result.valid && result.kind)
        else $error("grant notice did not follow handoff reply");

    // no command is taken while the queue walk is busy
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRD || state_reg == S_SWT) |-> !request.ready)
        else $error("accept during queue walk");

endmodule

// File: tb/sv/fifo_lock_table_tb.sv
`timescale 1ns / 100ps

module fifo_lock_table_tb;

    localparam int EXP_DEPTH = 256;
    localparam int MAX_ROWS  = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lkt_cmd_if request ();
    lkt_res_if result ();

    fifo_lock_table u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    always #5 clk = ~clk;

    // one command beat as the testbench sees it
    typedef struct {
        logic [lkt_pkg::CMD_W-1:0]  cmd;
        logic [lkt_pkg::LIDX_W-1:0] idx;
        logic [lkt_pkg::REQ_W-1:0]  who;
        logic                       create;
    } op_t;

    // directed row: command plus optional typed-in result check
    typedef struct {
        op_t           op;
        logic          has_exp;
        lkt_pkg::res_t exp;
    } row_t;

    // shadow of the lock table
    logic                         lt_valid [lkt_pkg::NUM_LOCKS];
    logic                         lt_held  [lkt_pkg::NUM_LOCKS];
    logic [lkt_pkg::ID_WIDTH-1:0] lt_owner [lkt_pkg::NUM_LOCKS];
    logic [lkt_pkg::VER_W-1:0]    lt_ver   [lkt_pkg::NUM_LOCKS];
    logic [lkt_pkg::ID_WIDTH-1:0] lt_wq    [lkt_pkg::NUM_LOCKS][lkt_pkg::QUEUE_DEPTH];
    int                           lt_wcnt  [lkt_pkg::NUM_LOCKS];

    // expected result beats, ring indexed by running write/read counts
    lkt_pkg::res_t exp_ring [EXP_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;

    row_t rows [MAX_ROWS];
    int   nrows = 0;

    int   errors = 0;
    int   snd_idle_pct = 20;
    int   rcv_idle_pct = 56;
    bit   rcv_hold = 1'b0;
    int   quiet_cycles = 0;
    bit   done = 1'b0;

    function automatic lkt_pkg::res_t mk(logic k, logic [lkt_pkg::ST_W-1:0] st,
                                         logic [lkt_pkg::ID_WIDTH-1:0] o, logic hv,
                                         logic [lkt_pkg::VER_W-1:0] v, logic l);
        lkt_pkg::res_t r;
        r.kind = k; r.status = st; r.owner = o; r.holder_valid = hv;
        r.version = v; r.last = l;
        return r;
    endfunction

    task automatic exp_put(input lkt_pkg::res_t r);
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    function automatic lkt_pkg::res_t not_found();
        return mk(1'b0, lkt_pkg::ST_NOT_FOUND, '0, 1'b0, '0, 1'b1);
    endfunction

    // compute the result beats for one command and update the shadow table
    task automatic predict_lock_op(input op_t op);
        int i;
        int k;
        logic [lkt_pkg::ID_WIDTH-1:0] nxt;
        bit found;
        i = op.idx;
        if (!lt_valid[i])
        begin
            if (op.cmd == lkt_pkg::CMD_LOCK && op.create)
            begin
                lt_valid[i] = 1'b1; lt_held[i] = 1'b1; lt_owner[i] = op.who;
                lt_ver[i] = 64'd1; lt_wcnt[i] = 0;
                exp_put(mk(1'b0, lkt_pkg::ST_OK, op.who, 1'b1, 64'd1, 1'b1));
            end
            else
                exp_put(not_found());
            return;
        end
        case (op.cmd)
            lkt_pkg::CMD_LOCK:
                if (!lt_held[i])
                begin
                    lt_held[i] = 1'b1; lt_owner[i] = op.who; lt_ver[i] += 64'd1;
                    exp_put(mk(1'b0, lkt_pkg::ST_OK, op.who, 1'b1, lt_ver[i], 1'b1));
                end
                else if (lt_owner[i] == op.who)
                    exp_put(mk(1'b0, lkt_pkg::ST_RECURSIVE, op.who, 1'b1, lt_ver[i], 1'b1));
                else if (lt_wcnt[i] >= lkt_pkg::QUEUE_DEPTH)
                    exp_put(mk(1'b0, lkt_pkg::ST_QUEUE_FULL, '0, 1'b0, '0, 1'b1));
                else
                begin
                    lt_wq[i][lt_wcnt[i]] = op.who;
                    lt_wcnt[i]++;
                    exp_put(mk(1'b0, lkt_pkg::ST_PENDING, '0, 1'b0, '0, 1'b1));
                end
            lkt_pkg::CMD_UNLOCK:
                if (!lt_held[i] || lt_owner[i] != op.who)
                    exp_put(mk(1'b0, lkt_pkg::ST_HELD_OTHERS, '0, 1'b0, '0, 1'b1));
                else
                begin
                    lt_ver[i] += 64'd1;
                    if (lt_wcnt[i] > 0)
                    begin
                        nxt = lt_wq[i][0];
                        for (k = 1; k < lt_wcnt[i]; k++)
                            lt_wq[i][k-1] = lt_wq[i][k];
                        lt_wcnt[i]--;
                        lt_owner[i] = nxt;
                        exp_put(mk(1'b0, lkt_pkg::ST_OK, '0, 1'b0, '0, 1'b0));
                        exp_put(mk(1'b1, lkt_pkg::ST_OK, nxt, 1'b1, lt_ver[i], 1'b1));
                    end
                    else
                    begin
                        lt_held[i] = 1'b0; lt_owner[i] = '0;
                        exp_put(mk(1'b0, lkt_pkg::ST_OK, '0, 1'b0, '0, 1'b1));
                    end
                end
            lkt_pkg::CMD_CANCEL:
            begin
                found = 1'b0;
                for (k = 0; k < lt_wcnt[i]; k++)
                begin
                    if (found)
                        lt_wq[i][k-1] = lt_wq[i][k];
                    else if (lt_wq[i][k] == op.who)
                        found = 1'b1;
                end
                if (found)
                    lt_wcnt[i]--;
                exp_put(mk(1'b0, found ? lkt_pkg::ST_OK : lkt_pkg::ST_NOT_FOUND,
                    lt_held[i] ? lt_owner[i] : '0, lt_held[i], lt_ver[i], 1'b1));
            end
            default:
                exp_put(mk(1'b0, lkt_pkg::ST_OK, lt_held[i] ? lt_owner[i] : '0,
                    lt_held[i], lt_ver[i], 1'b1));
        endcase
    endtask

    // drive one command beat; predict at acceptance. Valid stays up for the
    // next beat unless the sender idles or waits for the results to drain.
    task automatic send_beat(input op_t op);
        if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct)
        begin
            request.valid <= 1'b0;
            @(negedge clk);
            while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct)
                @(negedge clk);
        end
        request.valid <= 1'b1;
        request.cmd <= op.cmd;
        request.lock_index <= op.idx;
        request.requester <= op.who;
        request.create_if_missing <= op.create;
        do @(posedge clk); while (!request.ready);
        predict_lock_op(op);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        request.valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic add_row(input op_t op, input logic has_exp, input lkt_pkg::res_t exp);
        rows[nrows].op = op;
        rows[nrows].has_exp = has_exp;
        rows[nrows].exp = exp;
        nrows++;
    endtask

    function automatic op_t mkop(logic [lkt_pkg::CMD_W-1:0] c, int idx, int who, logic cr);
        op_t o;
        o.cmd = c;
        o.idx = lkt_pkg::LIDX_W'(idx);
        o.who = lkt_pkg::REQ_W'(who);
        o.create = cr;
        return o;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n || rcv_hold)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // checker and watchdog
    always @(posedge clk)
    begin : p_check
        lkt_pkg::res_t got;
        lkt_pkg::res_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                got = mk(result.kind, result.status, result.owner_id,
                         result.holder_valid, result.lock_version, result.last);
                if (exp_wr == exp_rd)
                begin
                    errors++;
                    $display("%0t: unexpected result beat %p", $time, got);
                end
                else
                begin
                    want = exp_ring[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: result mismatch exp %p got %p", $time, want, got);
                    end
                end
            end
            if ((result.valid && result.ready) || (request.valid && request.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000 && !done)
            begin
                $display("fifo_lock_table regression: fail");
                $finish;
            end
        end
    end

    // random op: hot-spot a few locks and a few clients so queues fill up
    function automatic op_t rand_op();
        op_t o;
        int r;
        r = $urandom_range(99);
        o.cmd = r < 40 ? lkt_pkg::CMD_LOCK : r < 70 ? lkt_pkg::CMD_UNLOCK :
                r < 85 ? lkt_pkg::CMD_CANCEL : lkt_pkg::CMD_QUERY;
        o.idx = ($urandom_range(9) < 8) ? lkt_pkg::LIDX_W'($urandom_range(3))
                                        : lkt_pkg::LIDX_W'($urandom_range(63));
        o.who = ($urandom_range(9) < 8) ? lkt_pkg::REQ_W'($urandom_range(11))
                                        : lkt_pkg::REQ_W'($urandom_range(65535));
        o.create = ($urandom_range(3) != 0);
        // unlocks mostly by the owner so hand-offs happen
        if (o.cmd == lkt_pkg::CMD_UNLOCK && lt_valid[o.idx] && lt_held[o.idx]
            && $urandom_range(3) != 0)
            o.who = lt_owner[o.idx];
        return o;
    endfunction

    initial
    begin
        int phase;
        int n;
        request.valid = 1'b0;
        request.cmd = lkt_pkg::CMD_LOCK;
        request.lock_index = '0;
        request.requester = '0;
        request.create_if_missing = 1'b0;
        for (int i = 0; i < lkt_pkg::NUM_LOCKS; i++)
        begin
            lt_valid[i] = 1'b0; lt_held[i] = 1'b0; lt_owner[i] = '0; lt_ver[i] = '0;
            lt_wcnt[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows; has_exp=0 rows rely on the shadow table only
        add_row(mkop(lkt_pkg::CMD_QUERY, 63, 16'hffff, 1'b1), 1'b1, not_found());
        add_row(mkop(lkt_pkg::CMD_LOCK, 63, 16'hffff, 1'b0), 1'b1, not_found());
        add_row(mkop(lkt_pkg::CMD_UNLOCK, 0, 0, 1'b0), 1'b1, not_found());
        add_row(mkop(lkt_pkg::CMD_CANCEL, 0, 0, 1'b0), 1'b1, not_found());
        add_row(mkop(lkt_pkg::CMD_LOCK, 63, 16'hffff, 1'b1), 1'b1,
                mk(1'b0, lkt_pkg::ST_OK, 16'hffff, 1'b1, 64'd1, 1'b1));
        add_row(mkop(lkt_pkg::CMD_LOCK, 63, 16'hffff, 1'b1), 1'b1,
                mk(1'b0, lkt_pkg::ST_RECURSIVE, 16'hffff, 1'b1, 64'd1, 1'b1));
        add_row(mkop(lkt_pkg::CMD_UNLOCK, 63, 0, 1'b0), 1'b1,
                mk(1'b0, lkt_pkg::ST_HELD_OTHERS, '0, 1'b0, '0, 1'b1));
        add_row(mkop(lkt_pkg::CMD_LOCK, 0, 0, 1'b1), 1'b1,
                mk(1'b0, lkt_pkg::ST_OK, '0, 1'b1, 64'd1, 1'b1));
        // fill the queue of lock 0, then overflow it
        for (int w = 1; w <= lkt_pkg::QUEUE_DEPTH; w++)
            add_row(mkop(lkt_pkg::CMD_LOCK, 0, w, 1'b0), 1'b1,
                    mk(1'b0, lkt_pkg::ST_PENDING, '0, 1'b0, '0, 1'b1));
        add_row(mkop(lkt_pkg::CMD_LOCK, 0, 99, 1'b0), 1'b1,
                mk(1'b0, lkt_pkg::ST_QUEUE_FULL, '0, 1'b0, '0, 1'b1));
        add_row(mkop(lkt_pkg::CMD_CANCEL, 0, lkt_pkg::QUEUE_DEPTH, 1'b0), 1'b0, '0);
        add_row(mkop(lkt_pkg::CMD_CANCEL, 0, 3, 1'b0), 1'b0, '0);
        add_row(mkop(lkt_pkg::CMD_CANCEL, 0, 1234, 1'b0), 1'b0, '0);
        add_row(mkop(lkt_pkg::CMD_UNLOCK, 0, 0, 1'b0), 1'b0, '0);   // hand-off to waiter 1
        add_row(mkop(lkt_pkg::CMD_QUERY, 0, 0, 1'b0), 1'b0, '0);
        add_row(mkop(lkt_pkg::CMD_UNLOCK, 63, 16'hffff, 1'b0), 1'b0, '0); // free, no waiters
        add_row(mkop(lkt_pkg::CMD_QUERY, 63, 0, 1'b0), 1'b1,
                mk(1'b0, lkt_pkg::ST_OK, '0, 1'b0, 64'd2, 1'b1));
        add_row(mkop(lkt_pkg::CMD_LOCK, 63, 16'h8000, 1'b0), 1'b1,
                mk(1'b0, lkt_pkg::ST_OK, 16'h8000, 1'b1, 64'd3, 1'b1));
        add_row(mkop(lkt_pkg::CMD_UNLOCK, 63, 16'h8000, 1'b1), 1'b0, '0);
        for (int j = 0; j < nrows; j++)
        begin
            send_beat(rows[j].op);
            // typed-in value must agree with the shadow prediction (last queued)
            if (rows[j].has_exp && exp_ring[(exp_wr - 1) % EXP_DEPTH] !== rows[j].exp)
            begin
                errors++;
                $display("%0t: row %0d exp %p model %p", $time, j, rows[j].exp,
                         exp_ring[(exp_wr - 1) % EXP_DEPTH]);
            end
        end
        wait_drained();

        // long receiver hold-off while commands keep coming: input backs up
        fork
            begin
                rcv_hold = 1'b1;
                repeat (300) @(negedge clk);
                rcv_hold = 1'b0;
            end
            for (int j = 0; j < 40; j++)
                send_beat(rand_op());
        join
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            snd_idle_pct = phase == 0 ? 20 : phase == 1 ? 56 : 0;
            rcv_idle_pct = phase == 0 ? 56 : phase == 1 ? 20 : 0;
            for (n = 0; n < 520; n++)
            begin
                send_beat(rand_op());
                // sender pause until the result stream is empty
                if (n == 260)
                    wait_drained();
            end
        end
        wait_drained();
        done = 1'b1;
        if (errors == 0)
            $display("fifo_lock_table regression: pass");
        else
            $display("fifo_lock_table regression: fail");
        $finish;
    end
endmodule
